// ----- src/bmh_pkg.sv -----
// Shared types, constants and helper functions for the byte mixing hash.
package bmh_pkg;

  // Hash geometry
  localparam int WORD_COUNT  = 8;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Transaction op codes
  localparam logic [1:0] OP_ABSORB        = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH        = 2'd2;

  // Mixing constants
  localparam logic [WORD_W-1:0] GOLDEN_ADD    = 32'h9e3779b9;
  localparam logic [4:0]        POS_MOD_LAST  = 5'd28;
  localparam logic [IDX_W-1:0]  LAST_WORD_IDX = 3'd7;

  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] word_bank_t;

  // Element 0 is the low element of the packed bank
  localparam word_bank_t INIT_WORDS = {
    32'h1337c0de, 32'h8badf00d, 32'hcafebabe, 32'h0badc0de,
    32'hfeedface, 32'hdeadbeef, 32'h9abcdef0, 32'h12345678
  };

  // Classified transaction held in the queue
  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic [7:0] data_byte;
  } bmh_item_t;

  // Digest handoff from the mixing core to the output stage
  typedef struct packed {
    logic       load;
    word_bank_t words;
  } digest_load_t;

  // Byte modulo 31: 32 is 1 mod 31, so fold the top three bits onto the low five
  function automatic logic [4:0] mod31(input logic [7:0] b);
    logic [5:0] s;
    s = {3'b000, b[7:5]} + {1'b0, b[4:0]};
    if (s >= 6'd31) begin
      s = s - 6'd31;
    end
    return s[4:0];
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> n;
    return d[WORD_W-1:0];
  endfunction

endpackage

// ----- src/bmh_front.sv -----
// Front end: decodes input transactions and buffers them in a short queue.
module bmh_front import bmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  output bmh_item_t  q_item,
  input  logic       q_pop
);

  logic                in_accept;
  logic                cls_push;
  bmh_item_t           cls_item;
  logic                push_en;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  bmh_item_t           q_mem_r [QUEUE_DEPTH];

  // Decode op; undefined op is dropped here
  always_comb begin
    cls_push           = 1'b1;
    cls_item.absorb    = 1'b0;
    cls_item.finish    = 1'b0;
    cls_item.data_byte = in_data_byte;
    unique case (in_op)
      OP_ABSORB: begin
        cls_item.absorb = 1'b1;
      end
      OP_ABSORB_FINISH: begin
        cls_item.absorb = 1'b1;
        cls_item.finish = 1'b1;
      end
      OP_FINISH: begin
        cls_item.finish = 1'b1;
      end
      default: begin
        cls_push = 1'b0;
      end
    endcase
  end

  assign in_stall  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign push_en   = in_accept && cls_push;
  assign q_valid   = (count_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push_en && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_en && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Write queue storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// ----- src/bmh_core.sv -----
// Mixing core: two-stage word update over a rotating bank of eight words.
module bmh_core import bmh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  bmh_item_t    q_item,
  output logic         q_pop,
  input  logic         load_ok,
  output digest_load_t dig
);

  // ring_r[k] holds word (pos + k) mod 8, so reads sit at fixed slots
  word_bank_t        ring_r, ring_nxt;
  word_bank_t        merged;
  word_bank_t        rot_ring;
  logic [2*WORD_COUNT*WORD_W-1:0] dbl;
  logic [WORD_W-1:0] pos_r, pos_nxt;
  logic [4:0]        pm29_r, pm29_nxt;

  logic              pipe_vld_r, pipe_abs_r, pipe_fin_r;
  logic [WORD_W-1:0] pipe_lhs_r, pipe_rhs_r;
  logic [IDX_W-1:0]  pipe_off_r;

  logic              rotate;
  logic [WORD_W-1:0] lhs, rhs, new_word;
  logic [4:0]        rotl_amt, rotr_amt;

  // Hold pops behind a finish in flight and until the output stage is free
  assign q_pop  = q_valid && !(pipe_vld_r && pipe_fin_r) && (!q_item.finish || load_ok);
  assign rotate = q_pop && q_item.absorb;

  // First stage: xor, rotate left, rotate neighbor right
  assign rotl_amt = mod31(q_item.data_byte) + 5'd1;
  assign rotr_amt = pm29_r + 5'd1;
  assign lhs = rotl32(ring_r[0] ^ ({24'h0, q_item.data_byte} + pos_r), rotl_amt);
  assign rhs = rotr32(ring_r[1], rotr_amt);

  // Second stage: combine and add the golden constant
  assign new_word = (pipe_lhs_r ^ pipe_rhs_r) + GOLDEN_ADD;

  // Bank with the pending update merged in, no rotation behind a finish
  always_comb begin
    merged = ring_r;
    if (pipe_vld_r && pipe_abs_r) begin
      merged[WORD_COUNT-1] = new_word;
    end
  end

  // Restore word order for the digest
  assign dbl      = {merged, merged} << {pipe_off_r, 5'b00000};
  assign rot_ring = dbl[2*WORD_COUNT*WORD_W-1:WORD_COUNT*WORD_W];

  assign dig.load  = pipe_vld_r && pipe_fin_r;
  assign dig.words = rot_ring;

  // Rotate bank, land pending write, re-arm after finish
  always_comb begin
    ring_nxt = ring_r;
    if (rotate) begin
      for (int k = 0; k < WORD_COUNT - 1; k++) begin
        ring_nxt[k] = ring_r[k+1];
      end
      ring_nxt[WORD_COUNT-1] = ring_r[0];
    end
    if (pipe_vld_r && pipe_abs_r) begin
      if (rotate) begin
        ring_nxt[WORD_COUNT-2] = new_word;
      end else begin
        ring_nxt[WORD_COUNT-1] = new_word;
      end
    end
    if (pipe_vld_r && pipe_fin_r) begin
      ring_nxt = INIT_WORDS;
    end
  end

  // Step position counters
  always_comb begin
    pos_nxt  = pos_r;
    pm29_nxt = pm29_r;
    if (rotate) begin
      pos_nxt  = pos_r + 1'b1;
      pm29_nxt = (pm29_r >= POS_MOD_LAST) ? 5'd0 : pm29_r + 5'd1;
    end
    if (q_pop && q_item.finish) begin
      pos_nxt  = '0;
      pm29_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r     <= INIT_WORDS;
      pos_r      <= '0;
      pm29_r     <= '0;
      pipe_vld_r <= 1'b0;
      pipe_abs_r <= 1'b0;
      pipe_fin_r <= 1'b0;
    end else begin
      ring_r     <= ring_nxt;
      pos_r      <= pos_nxt;
      pm29_r     <= pm29_nxt;
      pipe_vld_r <= q_pop;
      pipe_abs_r <= rotate;
      pipe_fin_r <= q_pop && q_item.finish;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pipe_lhs_r <= lhs;
      pipe_rhs_r <= rhs;
      pipe_off_r <= pos_r[IDX_W-1:0] + {{(IDX_W-1){1'b0}}, q_item.absorb};
    end
  end

endmodule

// ----- src/bmh_emit.sv -----
// Output stage: holds a digest snapshot and sends its eight words in order.
module bmh_emit import bmh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  digest_load_t      dig,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [IDX_W-1:0]  out_word_index,
  output logic              out_last_word
);

  word_bank_t       buf_r;
  logic [IDX_W-1:0] cnt_r;
  logic             busy_r;
  logic             take;
  logic             last;

  assign last    = (cnt_r == LAST_WORD_IDX);
  assign take    = busy_r && !out_stall;
  assign load_ok = !busy_r || (take && last);

  assign out_valid       = busy_r;
  assign out_digest_word = buf_r[0];
  assign out_word_index  = cnt_r;
  assign out_last_word   = last;

  // Sequence the eight words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (dig.load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Load snapshot, shift down on each taken word
  always_ff @(posedge clk) begin
    if (dig.load) begin
      buf_r <= dig.words;
    end else if (take) begin
      for (int k = 0; k < WORD_COUNT - 1; k++) begin
        buf_r[k] <= buf_r[k+1];
      end
    end
  end

endmodule

// ----- src/byte_mixing_hash_256.sv -----
// Top level of the byte mixing 256-bit hash.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  in_op, in_data_byte
//   out      out_valid/out_stall  out_digest_word, out_word_index, out_last_word
//
// One byte transaction is taken per cycle unless stalled; the word update
// runs in two stages behind a four-entry queue. A finish sends eight words,
// one per cycle, from a snapshot buffer while absorbing goes on; a second
// finish waits until the previous digest has drained. Reset is synchronous.
// A stall on the output holds the current word; a finish queued behind it
// waits, later transactions fill the queue, then in_stall rises.
module byte_mixing_hash_256 import bmh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [IDX_W-1:0]  out_word_index,
  output logic              out_last_word
);

  logic         q_valid;
  bmh_item_t    q_item;
  logic         q_pop;
  logic         load_ok;
  digest_load_t dig;

  bmh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  bmh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .load_ok (load_ok),
    .dig     (dig)
  );

  bmh_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .dig             (dig),
    .load_ok         (load_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the byte mixing 256-bit hash: directed and random message traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmh_pkg::*;

  localparam logic [1:0] OP_UNDEF      = 2'd3;
  localparam int         LONG_HOLD     = 300;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         PHASE_ITEMS   = 120;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
  } byte_txn_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } digest_beat_t;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op        = OP_ABSORB;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [WORD_W-1:0] out_digest_word;
  logic [IDX_W-1:0]  out_word_index;
  logic              out_last_word;

  byte_txn_t    pending_q[$];
  digest_beat_t digest_q[$];
  idle_mode_t   idle_mode = IDLE_NONE;
  bit           hold_req  = 1'b0;
  int           hold_left = 0;
  int           mismatch_count = 0;

  // Predicted hash state
  logic [WORD_W-1:0] model_words [WORD_COUNT];
  logic [31:0]       byte_pos;
  logic [4:0]        pos_mod29;

  const logic [WORD_W-1:0] seed_words [WORD_COUNT] = '{
    32'h12345678, 32'h9abcdef0, 32'hdeadbeef, 32'hfeedface,
    32'h0badc0de, 32'hcafebabe, 32'h8badf00d, 32'h1337c0de
  };

  byte_mixing_hash_256 u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void rearm_hash();
    for (int k = 0; k < WORD_COUNT; k++) begin
      model_words[k] = seed_words[k];
    end
    byte_pos  = '0;
    pos_mod29 = '0;
  endfunction

  // Fold one message byte into the word picked by the position
  function automatic void mix_byte(input logic [7:0] b);
    logic [2:0]        sel;
    logic [2:0]        nsel;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] nw;
    int                lamt;
    int                ramt;
    sel  = byte_pos[2:0];
    nsel = sel + 3'd1;
    lamt = (int'(b) % 31) + 1;
    ramt = int'(pos_mod29) + 1;
    w    = model_words[sel] ^ ({24'd0, b} + byte_pos);
    w    = (w << lamt) | (w >> (32 - lamt));
    nw   = model_words[nsel];
    w    = w ^ ((nw >> ramt) | (nw << (32 - ramt)));
    model_words[sel] = w + 32'h9e3779b9;
    byte_pos  = byte_pos + 32'd1;
    pos_mod29 = (pos_mod29 >= 5'd28) ? 5'd0 : pos_mod29 + 5'd1;
  endfunction

  // Queue the eight digest words, then start a fresh message
  function automatic void emit_digest();
    digest_beat_t beat;
    for (int k = 0; k < WORD_COUNT; k++) begin
      beat.word = model_words[k];
      beat.idx  = IDX_W'(k);
      beat.last = (k == WORD_COUNT - 1);
      digest_q.insert(digest_q.size(), beat);
    end
    rearm_hash();
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 87;
      IDLE_BOTH:   return $urandom_range(99) < 27;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 87;
      IDLE_BOTH:     return $urandom_range(99) < 27;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t ERROR %s", $realtime, msg);
    end
  endfunction

  initial rearm_hash();

  // Driver: predict on each accepted transaction, then offer the next one
  always @(posedge clk) begin : driver
    byte_txn_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        case (in_op)
          OP_ABSORB: mix_byte(in_data_byte);
          OP_ABSORB_FINISH: begin
            mix_byte(in_data_byte);
            emit_digest();
          end
          OP_FINISH: emit_digest();
          default: ;
        endcase
      end
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() > 0 && !sender_idles()) begin
          nxt = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_op        <= nxt.op;
          in_data_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word, then pick the next stall
  always @(posedge clk) begin : monitor
    digest_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        flag_error($sformatf("unexpected word %h idx %0d last %0b",
                             out_digest_word, out_word_index, out_last_word));
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.word || out_word_index !== want.idx ||
            out_last_word !== want.last) begin
          flag_error($sformatf("exp word %h idx %0d last %0b, got %h idx %0d last %0b",
                               want.word, want.idx, want.last,
                               out_digest_word, out_word_index, out_last_word));
        end
      end
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_stalls();
    end
  end

  task automatic push(input logic [1:0] op, input logic [7:0] data);
    byte_txn_t t;
    t.op   = op;
    t.data = data;
    pending_q.insert(pending_q.size(), t);
  endtask

  // Wait until every transaction is taken and every digest word has come back
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || digest_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Messages with random bytes, mostly closed by a finish, plus some noise
  task automatic add_messages(input int count, input int max_len);
    int made;
    int len;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        push(OP_UNDEF, 8'($urandom));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(4 * max_len) : $urandom_range(max_len);
        for (int k = 0; k < len; k++) begin
          push(OP_ABSORB, 8'($urandom));
        end
        made += len;
        // leave some messages open so they run into the next one
        if (pick >= 10) begin
          push($urandom_range(1) ? OP_ABSORB_FINISH : OP_FINISH, 8'($urandom));
          made++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty messages, undefined op, byte extremes, rotate extremes
    push(OP_FINISH, 8'h00);
    push(OP_FINISH, 8'ha5);
    push(OP_UNDEF, 8'hff);
    push(OP_ABSORB, 8'h00);
    push(OP_ABSORB, 8'hff);
    push(OP_ABSORB, 8'd30);
    push(OP_ABSORB, 8'd31);
    push(OP_ABSORB, 8'd62);
    push(OP_UNDEF, 8'h00);
    push(OP_ABSORB_FINISH, 8'h80);
    push(OP_ABSORB_FINISH, 8'h01);
    push(OP_FINISH, 8'h5a);
    push(OP_ABSORB, 8'h7f);
    push(OP_ABSORB, 8'h55);
    push(OP_ABSORB, 8'haa);
    push(OP_ABSORB_FINISH, 8'hfe);
    drain();

    // Random traffic under each idling mode
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      add_messages(PHASE_ITEMS, 12);
      drain();
    end

    // Long receiver hold-off while short messages keep coming
    idle_mode = IDLE_NONE;
    hold_req  = 1'b1;
    add_messages(40, 2);
    drain();

    repeat (50) @(negedge clk);
    if (digest_q.size() != 0) begin
      flag_error($sformatf("%0d digest words never arrived", digest_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
src/bmh_pkg.sv
src/bmh_front.sv
src/bmh_core.sv
src/bmh_emit.sv
src/byte_mixing_hash_256.sv
verif/tb_top.sv
